[rtl/core/pfmt_pkg.sv]
// Shared types, codes and helpers for the printf directive formatter.
`default_nettype none
package pfmt_pkg;

    // Directive mode codes
    localparam logic [2:0] MODE_LITERAL  = 3'd0;
    localparam logic [2:0] MODE_CHAR     = 3'd1;
    localparam logic [2:0] MODE_UNSIGNED = 3'd2;
    localparam logic [2:0] MODE_SIGNED   = 3'd3;
    localparam logic [2:0] MODE_HEX_LO   = 3'd4;
    localparam logic [2:0] MODE_HEX_UP   = 3'd5;
    localparam logic [2:0] MODE_POINTER  = 3'd6;

    // Character select codes for the output character mux
    localparam logic [2:0] SEL_LIT   = 3'd0;
    localparam logic [2:0] SEL_ARGCH = 3'd1;
    localparam logic [2:0] SEL_SPACE = 3'd2;
    localparam logic [2:0] SEL_ZERO  = 3'd3;
    localparam logic [2:0] SEL_MINUS = 3'd4;
    localparam logic [2:0] SEL_DIGIT = 3'd5;

    localparam int DIG_DEPTH = 10;   // most digits of a 32-bit value (decimal)
    localparam int DIG_IDX_W = 4;
    localparam logic [6:0] PTR_DIGITS = 7'd8;

    // ceil(2^35 / 10): q = (v * DEC_RECIP) >> 35 is v / 10 for any 32-bit v
    localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic                 load;
        logic                 step;
        logic                 emit;
        logic [2:0]           sel;
        logic [DIG_IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic                 done;
        logic                 neg;
        logic [DIG_IDX_W-1:0] len;
    } dp_stat_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
        logic [7:0] c;
        begin
            if (d < 4'd10) begin
                c = CH_ZERO + {4'd0, d};
            end
            else begin
                c = (lower ? 8'h61 : 8'h41) + {4'd0, d - 4'd10};
            end
            return c;
        end
    endfunction

endpackage
`default_nettype wire

[rtl/core/pfmt_datapath.sv]
// Formatter datapath: argument magnitude, digit conversion, digit store, output char.
`default_nettype none
module pfmt_datapath
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [2:0]        in_mode,
    input  wire logic [31:0]       in_arg,
    input  wire logic [7:0]        in_lit,
    input  wire pfmt_pkg::dp_cmd_t cmd,
    output pfmt_pkg::dp_stat_t     stat,
    output logic [7:0]             out_char
);

    logic [31:0] v_reg;
    logic [7:0]  lit_reg;
    logic        hex_reg;
    logic        lower_reg;
    logic        neg_reg;
    logic [pfmt_pkg::DIG_IDX_W-1:0] len_reg;
    logic [3:0]  dig_reg [pfmt_pkg::DIG_DEPTH];
    logic [7:0]  char_reg;

    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] rem_full;
    logic [3:0]  digit;
    logic [31:0] v_next;
    logic        load_neg;
    logic [7:0]  char_next;

    // one digit per cycle: decimal through the reciprocal multiply, hex by a 4-bit shift
    always_comb
    begin
        prod     = {32'd0, v_reg} * {32'd0, pfmt_pkg::DEC_RECIP};
        quot     = {3'd0, prod[63:35]};
        rem_full = v_reg - {quot[28:0], 3'd0} - {quot[30:0], 1'b0};
        if (hex_reg) begin
            digit  = v_reg[3:0];
            v_next = {4'd0, v_reg[31:4]};
        end
        else begin
            digit  = rem_full[3:0];
            v_next = quot;
        end
    end

    assign load_neg = (in_mode == pfmt_pkg::MODE_SIGNED) && in_arg[31];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_reg <= '0;
        end
        else if (cmd.load) begin
            len_reg <= '0;
        end
        else if (cmd.step) begin
            len_reg <= len_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            v_reg     <= load_neg ? (32'd0 - in_arg) : in_arg;
            lit_reg   <= in_lit;
            neg_reg   <= load_neg;
            hex_reg   <= (in_mode == pfmt_pkg::MODE_HEX_LO) ||
                         (in_mode == pfmt_pkg::MODE_HEX_UP) ||
                         (in_mode == pfmt_pkg::MODE_POINTER);
            lower_reg <= (in_mode == pfmt_pkg::MODE_HEX_LO);
        end
        else if (cmd.step) begin
            v_reg            <= v_next;
            dig_reg[len_reg] <= digit;
        end
    end

    always_comb
    begin
        unique case (cmd.sel)
            pfmt_pkg::SEL_LIT:   char_next = lit_reg;
            pfmt_pkg::SEL_ARGCH: char_next = v_reg[7:0];
            pfmt_pkg::SEL_SPACE: char_next = pfmt_pkg::CH_SPACE;
            pfmt_pkg::SEL_ZERO:  char_next = pfmt_pkg::CH_ZERO;
            pfmt_pkg::SEL_MINUS: char_next = pfmt_pkg::CH_MINUS;
            pfmt_pkg::SEL_DIGIT: char_next = pfmt_pkg::digit_char(dig_reg[cmd.idx], lower_reg);
            default:             char_next = pfmt_pkg::CH_SPACE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit) begin
            char_reg <= char_next;
        end
    end

    // conversion ends once at least one digit exists and the value is used up
    assign stat.done = (len_reg != '0) && (v_reg == 32'd0);
    assign stat.neg  = neg_reg;
    assign stat.len  = len_reg;
    assign out_char  = char_reg;

endmodule
`default_nettype wire

[rtl/core/pfmt_ctrl.sv]
// Formatter controller: directive sequencing, pad counters and output handshake.
`default_nettype none
module pfmt_ctrl
#(
    parameter int MAX_WIDTH = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        in_mode,
    input  wire logic [6:0]        in_width,
    input  wire logic              in_zero_fill,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_last,
    output pfmt_pkg::dp_cmd_t      cmd,
    input  wire pfmt_pkg::dp_stat_t stat
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ONE  = 3'd1;
    localparam logic [2:0] ST_CONV = 3'd2;
    localparam logic [2:0] ST_PLAN = 3'd3;
    localparam logic [2:0] ST_RUN1 = 3'd4;
    localparam logic [2:0] ST_SIGN = 3'd5;
    localparam logic [2:0] ST_RUN2 = 3'd6;
    localparam logic [2:0] ST_DIGS = 3'd7;

    localparam logic [6:0] WIDTH_CAP = 7'(MAX_WIDTH);

    logic [2:0] state_reg, state_next;
    logic [2:0] mode_reg, mode_next;
    logic [6:0] width_reg, width_next;
    logic       zf_reg, zf_next;
    logic [6:0] cnt1_reg, cnt1_next;
    logic [6:0] cnt2_reg, cnt2_next;
    logic [2:0] sel1_reg, sel1_next;
    logic [2:0] sel2_reg, sel2_next;
    logic       sgn_reg, sgn_next;
    logic [pfmt_pkg::DIG_IDX_W-1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_last_reg, out_last_next;

    logic       slot_free;
    logic       emit_last;
    logic [6:0] len7;
    logic [6:0] pad_num;
    logic [6:0] pad_neg;
    logic [6:0] ptr_pad;
    logic [6:0] ptr_zero;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        len7     = {3'd0, stat.len};
        pad_num  = (width_reg > len7) ? (width_reg - len7) : 7'd0;
        pad_neg  = (width_reg > (len7 + 7'd1)) ? (width_reg - len7 - 7'd1) : 7'd0;
        ptr_pad  = (width_reg > pfmt_pkg::PTR_DIGITS) ? (width_reg - pfmt_pkg::PTR_DIGITS)
                                                      : 7'd0;
        ptr_zero = pfmt_pkg::PTR_DIGITS - len7;
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        width_next = width_reg;
        zf_next    = zf_reg;
        cnt1_next  = cnt1_reg;
        cnt2_next  = cnt2_reg;
        sel1_next  = sel1_reg;
        sel2_next  = sel2_reg;
        sgn_next   = sgn_reg;
        idx_next   = idx_reg;
        in_ready   = 1'b0;
        emit_last  = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.sel    = pfmt_pkg::SEL_SPACE;
        cmd.idx    = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    mode_next  = in_mode;
                    width_next = (in_width > WIDTH_CAP) ? WIDTH_CAP : in_width;
                    zf_next    = in_zero_fill;
                    priority if (in_mode == pfmt_pkg::MODE_LITERAL ||
                                 in_mode == pfmt_pkg::MODE_CHAR) begin
                        state_next = ST_ONE;
                    end
                    else if (in_mode <= pfmt_pkg::MODE_POINTER) begin
                        state_next = ST_CONV;
                    end
                    else begin
                        state_next = ST_IDLE;   // unused mode: nothing to send
                    end
                end
            end
            ST_ONE:
            begin
                cmd.sel = (mode_reg == pfmt_pkg::MODE_LITERAL) ? pfmt_pkg::SEL_LIT
                                                                : pfmt_pkg::SEL_ARGCH;
                if (slot_free) begin
                    cmd.emit   = 1'b1;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CONV:
            begin
                if (stat.done) begin
                    state_next = ST_PLAN;
                end
                else begin
                    cmd.step = 1'b1;
                end
            end
            ST_PLAN:
            begin
                idx_next   = stat.len - 1'b1;
                cnt2_next  = 7'd0;
                sgn_next   = 1'b0;
                sel1_next  = zf_reg ? pfmt_pkg::SEL_ZERO : pfmt_pkg::SEL_SPACE;
                sel2_next  = pfmt_pkg::SEL_ZERO;
                cnt1_next  = pad_num;
                if (mode_reg == pfmt_pkg::MODE_POINTER) begin
                    sel1_next = pfmt_pkg::SEL_SPACE;
                    cnt1_next = ptr_pad;
                    cnt2_next = ptr_zero;
                end
                else if (mode_reg == pfmt_pkg::MODE_SIGNED && stat.neg) begin
                    sgn_next = 1'b1;
                    if (zf_reg) begin
                        cnt1_next = 7'd0;       // sign first, zeros after it
                        cnt2_next = pad_neg;
                    end
                    else begin
                        sel1_next = pfmt_pkg::SEL_SPACE;
                        cnt1_next = pad_neg;    // spaces first, then the sign
                    end
                end
                state_next = ST_RUN1;
            end
            ST_RUN1:
            begin
                cmd.sel = sel1_reg;
                if (cnt1_reg == 7'd0) begin
                    state_next = sgn_reg ? ST_SIGN : ST_RUN2;
                end
                else if (slot_free) begin
                    cmd.emit  = 1'b1;
                    cnt1_next = cnt1_reg - 7'd1;
                end
            end
            ST_SIGN:
            begin
                cmd.sel = pfmt_pkg::SEL_MINUS;
                if (slot_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_RUN2;
                end
            end
            ST_RUN2:
            begin
                cmd.sel = sel2_reg;
                if (cnt2_reg == 7'd0) begin
                    state_next = ST_DIGS;
                end
                else if (slot_free) begin
                    cmd.emit  = 1'b1;
                    cnt2_next = cnt2_reg - 7'd1;
                end
            end
            ST_DIGS:
            begin
                cmd.sel = pfmt_pkg::SEL_DIGIT;
                if (slot_free) begin
                    cmd.emit = 1'b1;
                    if (idx_reg == '0) begin
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_last_next  = emit_last;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        width_reg    <= width_next;
        zf_reg       <= zf_next;
        cnt1_reg     <= cnt1_next;
        cnt2_reg     <= cnt2_next;
        sel1_reg     <= sel1_next;
        sel2_reg     <= sel2_next;
        sgn_reg      <= sgn_next;
        idx_reg      <= idx_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;

endmodule
`default_nettype wire

[rtl/core/printf_directive_formatter_unit.sv]
// Top level of the printf directive formatter: stream ports, controller and datapath.
`default_nettype none
// Formats one parsed printf-style directive per input transfer into a run of ASCII
// characters, one character per output transfer, with tlast on the final character.
// Modes (tuser): literal, char, unsigned, signed, hex lower, hex upper, pointer; mode 7
// is accepted and produces nothing. Numbers other than pointers carry no leading zeros
// and are padded on the left to field_width (capped at MAX_WIDTH) with spaces or zeros;
// a negative signed value puts '-' ahead of zero padding or after space padding;
// pointer mode prints eight upper-case hex digits space-padded to the width. Timing:
// a directive is taken only in the idle state, so the unit works on one directive at a
// time. Literal and char pass from the idle state straight to their output state.
// Numbers run a digit loop of one digit per cycle through a single reciprocal multiply
// until the value is used up (D digits, D = 1..10 decimal, 1..8 hex), then a planning
// state, then the pad characters, the sign if any and the digits; each of the two pad
// runs ends in a state that emits nothing, empty or not. A character that is ready
// waits while the output register is still held. The output register lets the next
// directive start converting while the last character of the previous run still waits
// to be taken.
module printf_directive_formatter_unit
#(
    parameter int MAX_WIDTH = 64    // 11..64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [6:0] field_width, [7] zero_fill, [39:8] arg_value, [47:40] literal_char
    input  wire logic [47:0] s_axis_tdata,
    // [2:0] mode
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] out_char
    output logic [7:0]       m_axis_tdata,
    // last_char
    output logic             m_axis_tlast
);

    pfmt_pkg::dp_cmd_t  cmd;
    pfmt_pkg::dp_stat_t stat;

    // sequencing: pad runs, sign, digits and the output valid/last flags
    pfmt_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_mode      (s_axis_tuser),
        .in_width     (s_axis_tdata[6:0]),
        .in_zero_fill (s_axis_tdata[7]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_last     (m_axis_tlast),
        .cmd          (cmd),
        .stat         (stat)
    );

    // digit conversion and the registered output character
    pfmt_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_mode  (s_axis_tuser),
        .in_arg   (s_axis_tdata[39:8]),
        .in_lit   (s_axis_tdata[47:40]),
        .cmd      (cmd),
        .stat     (stat),
        .out_char (m_axis_tdata)
    );

endmodule
`default_nettype wire
